// ----- src/wrlc_pkg.sv -----
// ----------------------------------------------------------------------------
// wrlc_pkg: shared types and constants
// Command codes, request phases, error codes and controller/datapath links.
// ----------------------------------------------------------------------------
package wrlc_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE     = 2'd0,
        CMD_LINK     = 2'd1,
        CMD_STATUS   = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_QUEUED   = 3'd1,
        PH_BCAST    = 3'd2,
        PH_COMPLETE = 3'd3,
        PH_UNCONF   = 3'd4,
        PH_FAILED   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MALFORMED = 2'd1,
        ERR_BUSY      = 2'd2,
        ERR_RADIO     = 2'd3
    } err_t;

    localparam logic [30:0] ID_LIMIT = 31'h7fffffff;
    localparam logic [7:0]  CH_LF    = 8'h0a;
    localparam logic [7:0]  CH_CR    = 8'h0d;
    localparam logic [7:0]  CH_LO    = 8'h20;
    localparam logic [7:0]  CH_HI    = 8'h7e;
    localparam int          STATUS_LEN = 12;
    localparam int          WAKE_LEN   = 11;

    // Expected status line characters; the wake text shares the first six.
    function automatic logic [7:0] status_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0: c = "S";  4'd1: c = "P";  4'd2: c = "W";  4'd3: c = "B";
            4'd4: c = "1";  4'd5: c = " ";  4'd6: c = "S";  4'd7: c = "T";
            4'd8: c = "A";  4'd9: c = "T";  4'd10: c = "U"; 4'd11: c = "S";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] wake_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd6: c = "W";  4'd7: c = "A";  4'd8: c = "K";  4'd9: c = "E";
            4'd10: c = " ";
            default: c = status_char(i);
        endcase
        return c;
    endfunction

    // Commands from controller to datapath.
    typedef struct packed {
        logic scan_start;   // begin parsing the stored line
        logic scan_step;    // consume one character of the line
        logic finish;       // apply the parse verdict
        logic immediate;    // act on a non-byte item or plain byte
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic need_parse;   // item is a line feed on a good line
        logic scan_done;    // parse verdict known
    } dp_stat_t;

endpackage

// ----- src/wrlc_datapath.sv -----
// ----------------------------------------------------------------------------
// wrlc_datapath: line store, parser and request state
// Holds the line, parser and request state; the parser walks the line one character a cycle.
// ----------------------------------------------------------------------------
module wrlc_datapath #(
    parameter int MAX_LINE_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wrlc_pkg::dp_cmd_t   cmd,
    output wrlc_pkg::dp_stat_t  stat,
    input  logic [1:0]          command,
    input  logic [7:0]          data_byte,
    input  logic                link_up,
    input  logic                dispatch_ok,
    input  logic                radio_failed,
    input  logic                radio_initialized,
    input  logic                radio_armed,
    input  logic                wake_configured,
    input  logic                wake_busy,
    input  logic [31:0]         burst_count,
    input  logic [31:0]         radio_failure_count,
    output logic                byte_taken,
    output logic                response_valid,
    output logic [1:0]          error_code,
    output logic [2:0]          request_state,
    output logic [30:0]         current_request,
    output logic [31:0]         accepted_count,
    output logic [31:0]         bursts_reported,
    output logic [31:0]         failure_total,
    output logic                ready_flag,
    output logic                configured_flag,
    output logic                busy_flag,
    output logic                dispatch_wanted
);
    import wrlc_pkg::*;

    localparam int AW = $clog2(MAX_LINE_BYTES);
    localparam int LW = $clog2(MAX_LINE_BYTES + 1);

    logic [7:0]    mem [MAX_LINE_BYTES];
    logic [7:0]    rd_data_reg;
    logic [LW-1:0] len_reg;
    logic          bad_reg, link_reg;
    phase_t        phase_reg;
    logic [30:0]   id_reg;
    logic [31:0]   acc_reg, lfail_reg, bstart_reg, fstart_reg, rb_reg, rf_reg;
    logic          f_failed, f_ready, f_conf, f_busy;

    // Parser state.
    logic [LW-1:0] eff_len_reg, pos_reg;
    logic [31:0]   num_reg;
    logic          st_ok_reg, wk_ok_reg, dig_ok_reg, scanning_reg, done_reg;

    logic active, busy, pend;
    assign active = (phase_reg == PH_QUEUED) || (phase_reg == PH_BCAST);
    assign busy   = active || (!f_failed && f_busy);
    assign pend   = (phase_reg == PH_QUEUED) && f_ready && !f_failed && f_conf && !f_busy;

    logic is_lf, store_ok;
    assign is_lf    = (cmd_t'(command) == CMD_BYTE) && (data_byte == CH_LF) && link_reg;
    assign store_ok = (len_reg < LW'(MAX_LINE_BYTES)) &&
                      ((data_byte == CH_CR) || (data_byte >= CH_LO && data_byte <= CH_HI));
    assign stat.need_parse = is_lf && !bad_reg;
    assign stat.scan_done  = done_reg;

    // Line store writes and the parser's registered reads.
    logic [LW-1:0] rd_addr;
    assign rd_addr = cmd.scan_start ? LW'(0) : pos_reg + LW'(1);
    always_ff @(posedge clk)
    begin
        if (cmd.immediate && cmd_t'(command) == CMD_BYTE && link_reg && !is_lf &&
            store_ok && !bad_reg)
        begin
            mem[len_reg[AW-1:0]] <= data_byte;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    // Last stored byte for the trailing CR check, kept beside the store.
    logic [7:0] last_byte_reg;

    // Parser step values.
    logic [3:0]  pidx;
    logic [7:0]  ch;
    logic [3:0]  dig;
    logic [31:0] num10;
    logic        is_dig, ovf;
    assign pidx   = (pos_reg < LW'(STATUS_LEN)) ? pos_reg[3:0] : 4'd0;
    assign ch     = rd_data_reg;
    assign is_dig = (ch >= "0") && (ch <= "9");
    assign dig    = ch[3:0] - 4'd0;
    assign num10  = {num_reg[28:0], 3'b000} + {num_reg[30:0], 1'b0} + {28'd0, dig};
    assign ovf    = (num_reg > 32'd214748364) ||
                    ((num_reg == 32'd214748364) && (dig > 4'd7));

    // Parse verdict.
    err_t   verdict;
    logic   accept;
    always_comb
    begin
        verdict = ERR_NONE;
        accept  = 1'b0;
        if (st_ok_reg && eff_len_reg == LW'(STATUS_LEN))
            verdict = ERR_NONE;
        else if (!wk_ok_reg || eff_len_reg <= LW'(WAKE_LEN) || !dig_ok_reg)
            verdict = ERR_MALFORMED;
        else if (num_reg == 32'd0)
            verdict = ERR_MALFORMED;
        else if (num_reg[30:0] == id_reg)
            verdict = ERR_NONE;
        else if (busy)
            verdict = ERR_BUSY;
        else if (f_failed)
            verdict = ERR_RADIO;
        else
            accept = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0; bad_reg <= 1'b0; link_reg <= 1'b0; phase_reg <= PH_IDLE;
            id_reg <= '0; acc_reg <= '0; lfail_reg <= '0; bstart_reg <= '0;
            fstart_reg <= '0; rb_reg <= '0; rf_reg <= '0;
            {f_failed, f_ready, f_conf, f_busy} <= '0;
            scanning_reg <= 1'b0; done_reg <= 1'b0;
            byte_taken <= 1'b0; response_valid <= 1'b0; error_code <= ERR_NONE;
            eff_len_reg <= '0; pos_reg <= '0; num_reg <= '0;
            st_ok_reg <= 1'b0; wk_ok_reg <= 1'b0; dig_ok_reg <= 1'b0;
            last_byte_reg <= '0;
        end
        else
        begin
            if (cmd.immediate)
            begin
                byte_taken     <= (cmd_t'(command) == CMD_BYTE) && link_reg;
                response_valid <= is_lf;
                error_code     <= is_lf ? ERR_MALFORMED : ERR_NONE;
                case (cmd_t'(command))
                    CMD_BYTE:
                    begin
                        if (link_reg)
                        begin
                            if (is_lf)
                            begin
                                len_reg <= '0; bad_reg <= 1'b0;
                            end
                            else if (!store_ok)
                                bad_reg <= 1'b1;
                            else if (!bad_reg)
                            begin
                                len_reg <= len_reg + LW'(1);
                                last_byte_reg <= data_byte;
                            end
                        end
                    end
                    CMD_LINK:
                    begin
                        if (!link_up)
                        begin
                            len_reg <= '0; bad_reg <= 1'b0;
                        end
                        link_reg <= link_up;
                    end
                    CMD_STATUS:
                    begin
                        if (radio_failed && !f_failed)
                            lfail_reg <= lfail_reg + 32'd1;
                        {f_failed, f_ready, f_conf, f_busy} <=
                            {radio_failed, radio_armed, wake_configured, wake_busy};
                        rb_reg <= burst_count;
                        rf_reg <= radio_failure_count;
                        if (active || id_reg == 31'd0)
                        begin
                            if (radio_failed)
                                phase_reg <= PH_FAILED;
                            else if (radio_initialized && !wake_configured)
                                phase_reg <= PH_UNCONF;
                            else if (active && phase_reg == PH_BCAST)
                            begin
                                if (radio_failure_count != fstart_reg)
                                    phase_reg <= PH_FAILED;
                                else if (burst_count != bstart_reg && !wake_busy)
                                    phase_reg <= PH_COMPLETE;
                            end
                        end
                    end
                    default:
                    begin
                        if (pend)
                        begin
                            if (dispatch_ok)
                            begin
                                bstart_reg <= rb_reg; fstart_reg <= rf_reg;
                                phase_reg <= PH_BCAST;
                            end
                            else
                            begin
                                lfail_reg <= lfail_reg + 32'd1;
                                phase_reg <= PH_FAILED;
                            end
                        end
                    end
                endcase
            end

            // Character scan: one registered store read per step.
            done_reg <= cmd.scan_step && scanning_reg && !cmd.scan_start &&
                        (pos_reg >= eff_len_reg);
            if (cmd.scan_start)
            begin
                eff_len_reg <= (len_reg != '0 && last_byte_reg == CH_CR) ?
                               len_reg - LW'(1) : len_reg;
                pos_reg <= '0; num_reg <= '0;
                st_ok_reg <= 1'b1; wk_ok_reg <= 1'b1; dig_ok_reg <= 1'b1;
                scanning_reg <= 1'b1;
            end
            else if (cmd.scan_step && scanning_reg)
            begin
                if (pos_reg >= eff_len_reg)
                    scanning_reg <= 1'b0;
                else
                begin
                    if (pos_reg < LW'(STATUS_LEN) && ch != status_char(pidx))
                        st_ok_reg <= 1'b0;
                    if (pos_reg < LW'(WAKE_LEN))
                    begin
                        if (ch != wake_char(pidx))
                            wk_ok_reg <= 1'b0;
                    end
                    else if (!is_dig || ovf)
                        dig_ok_reg <= 1'b0;
                    else
                        num_reg <= num10;
                    pos_reg <= pos_reg + LW'(1);
                end
            end

            // Apply the verdict and report the line.
            if (cmd.finish)
            begin
                byte_taken     <= 1'b1;
                response_valid <= 1'b1;
                error_code     <= verdict;
                len_reg        <= '0;
                bad_reg        <= 1'b0;
                if (accept)
                begin
                    id_reg    <= num_reg[30:0];
                    phase_reg <= PH_QUEUED;
                    acc_reg   <= acc_reg + 32'd1;
                end
            end
        end
    end

    assign request_state   = phase_reg;
    assign current_request = id_reg & ID_LIMIT;
    assign accepted_count  = acc_reg;
    assign bursts_reported = rb_reg;
    assign failure_total   = rf_reg + lfail_reg;
    assign ready_flag      = f_ready;
    assign configured_flag = f_conf;
    assign busy_flag       = busy;
    assign dispatch_wanted = pend;

    // A scan never walks past the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        scanning_reg |-> pos_reg <= eff_len_reg)
        else $error("scan position beyond line end");
    // Stored length never exceeds the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_LINE_BYTES))
        else $error("line length overflow");
    // An accepted id is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        $changed(id_reg) |-> id_reg != 31'd0)
        else $error("zero id accepted");

endmodule

// ----- src/wrlc_controller.sv -----
// ----------------------------------------------------------------------------
// wrlc_controller: transaction sequencer
// Accepts one input transaction, runs the parser when needed, holds the result.
// ----------------------------------------------------------------------------
module wrlc_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output wrlc_pkg::dp_cmd_t   cmd,
    input  wrlc_pkg::dp_stat_t  stat
);
    import wrlc_pkg::*;

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_OUT } state_t;
    state_t state_reg;
    logic   ov_reg;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    // Command decode from the current state.
    always_comb
    begin
        cmd = '0;
        if (state_reg == S_IDLE && in_valid && !ov_reg)
        begin
            cmd.scan_start = stat.need_parse;
            cmd.immediate  = !stat.need_parse;
        end
        if (state_reg == S_SCAN)
        begin
            cmd.scan_step = 1'b1;
            cmd.finish    = stat.scan_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid && !ov_reg)
                    begin
                        if (stat.need_parse)
                            state_reg <= S_SCAN;
                        else
                            ov_reg <= 1'b1;
                    end
                S_SCAN:
                    if (stat.scan_done)
                    begin
                        state_reg <= S_IDLE;
                        ov_reg    <= 1'b1;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // No input is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken with result pending");
    // Scan start and plain action never coincide.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan_start && cmd.immediate))
        else $error("conflicting datapath commands");
    // Finishing a scan raises the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished scan without result");

endmodule

// ----- src/wake_request_line_controller.sv -----
// ----------------------------------------------------------------------------
// wake_request_line_controller: host line parser and wake request control
// Collects host bytes into lines, parses status and wake commands and tracks
// the request state from radio snapshots and dispatch outcomes.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  input     in_valid / in_ready        command .. radio_failure_count
//  output    out_valid / out_ready      byte_taken .. dispatch_wanted
//
//  A plain item's result is registered and valid in the cycle after it is
//  taken; a line feed on a good line is parsed first, one stored character
//  per cycle through the line store's single read port. One item is handled
//  at a time and the input stalls while a result waits. Reset clears all
//  control state; the line store contents are not cleared.
// ----------------------------------------------------------------------------
module wake_request_line_controller #(
    parameter int MAX_LINE_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic        link_up,
    input  logic        dispatch_ok,
    input  logic        radio_failed,
    input  logic        radio_initialized,
    input  logic        radio_armed,
    input  logic        wake_configured,
    input  logic        wake_busy,
    input  logic [31:0] burst_count,
    input  logic [31:0] radio_failure_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_taken,
    output logic        response_valid,
    output logic [1:0]  error_code,
    output logic [2:0]  request_state,
    output logic [30:0] current_request,
    output logic [31:0] accepted_count,
    output logic [31:0] bursts_reported,
    output logic [31:0] failure_total,
    output logic        ready_flag,
    output logic        configured_flag,
    output logic        busy_flag,
    output logic        dispatch_wanted
);
    import wrlc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer.
    wrlc_controller u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
        .cmd, .stat
    );

    // State and parser.
    wrlc_datapath #(.MAX_LINE_BYTES(MAX_LINE_BYTES)) u_dp (
        .clk, .rst_n, .cmd, .stat,
        .command, .data_byte, .link_up, .dispatch_ok, .radio_failed,
        .radio_initialized, .radio_armed, .wake_configured, .wake_busy,
        .burst_count, .radio_failure_count,
        .byte_taken, .response_valid, .error_code, .request_state,
        .current_request, .accepted_count, .bursts_reported, .failure_total,
        .ready_flag, .configured_flag, .busy_flag, .dispatch_wanted
    );

endmodule

// ----- test/tb_wake_request_line_controller.sv -----
// ----------------------------------------------------------------------------
// tb_wake_request_line_controller: self-checking testbench
// Feeds host bytes, link changes, radio snapshots and dispatch outcomes. Each
// transaction is predicted by a behavioural model of the line parser and the
// request state machine, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_wake_request_line_controller;

    import wrlc_pkg::*;

    localparam int  LINE_MAX   = 64;
    localparam int  STALL_MAX  = 3000;
    localparam int  ITEM_GOAL  = 1800;
    // Protocol prefix bytes, followed by the status and wake keywords.
    localparam logic [47:0] PREFIX  = 48'h535057423120;
    localparam logic [47:0] KW_STAT = 48'h535441545553;
    localparam logic [39:0] KW_WAKE = 40'h57414b4520;

    typedef struct {
        cmd_t        cmd;
        logic [7:0]  data;
        logic        up;
        logic        ok;
        logic [4:0]  flags;   // failed, initialised, ready, configured, busy
        logic [31:0] bursts;
        logic [31:0] fails;
    } host_item_t;

    typedef struct {
        logic        taken;
        logic        resp;
        err_t        err;
        phase_t      phase;
        logic [30:0] id;
        logic [31:0] accepted;
        logic [31:0] bursts;
        logic [31:0] failures;
        logic        rdy;
        logic        conf;
        logic        busy;
        logic        wanted;
    } status_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = 2'd0;
    logic [7:0]  data_byte = 8'd0;
    logic        link_up = 1'b0;
    logic        dispatch_ok = 1'b0;
    logic        radio_failed = 1'b0;
    logic        radio_initialized = 1'b0;
    logic        radio_armed = 1'b0;
    logic        wake_configured = 1'b0;
    logic        wake_busy = 1'b0;
    logic [31:0] burst_count = 32'd0;
    logic [31:0] radio_failure_count = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        byte_taken;
    logic        response_valid;
    logic [1:0]  error_code;
    logic [2:0]  request_state;
    logic [30:0] current_request;
    logic [31:0] accepted_count;
    logic [31:0] bursts_reported;
    logic [31:0] failure_total;
    logic        ready_flag;
    logic        configured_flag;
    logic        busy_flag;
    logic        dispatch_wanted;

    wake_request_line_controller dut (.*);

    host_item_t  host_feed[$];
    status_rec_t expected_status[$];
    host_item_t  in_flight;
    int          cycle_no = 0;
    int          error_total = 0;
    int          stall_cycles = 0;
    int          hold_left = 0;
    logic [31:0] snap_bursts = 0;
    logic [31:0] snap_fails = 0;

    // Model state of the block.
    logic [7:0]  m_line[LINE_MAX];
    int          m_len = 0;
    bit          m_bad = 0;
    bit          m_link = 0;
    phase_t      m_phase = PH_IDLE;
    logic [30:0] m_id = '0;
    logic [31:0] m_accepted = 0;
    logic [31:0] m_local_fail = 0;
    logic [31:0] m_burst_base = 0;
    logic [31:0] m_fail_base = 0;
    bit          m_failed = 0, m_init = 0, m_ready = 0, m_conf = 0, m_rbusy = 0;
    logic [31:0] m_bursts = 0;
    logic [31:0] m_fails = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic bit model_active();
        return m_phase == PH_QUEUED || m_phase == PH_BCAST;
    endfunction

    function automatic bit model_busy();
        return model_active() || (!m_failed && m_rbusy);
    endfunction

    function automatic bit model_wanted();
        return m_phase == PH_QUEUED && m_ready && !m_failed && m_conf && !m_rbusy;
    endfunction

    // Parse a completed good line and apply the wake request rules.
    function automatic err_t parse_stored_line();
        int          n;
        longint      acc_id;
        int          d;
        bit          pfx_ok;
        bit          stat_ok;
        n = m_len;
        acc_id = 0;
        if (n != 0 && m_line[n-1] == CH_CR)
            n--;
        pfx_ok = n >= 6;
        for (int i = 0; i < 6 && i < n; i++)
            if (m_line[i] != PREFIX[47-8*i -: 8])
                pfx_ok = 0;
        stat_ok = pfx_ok && n == 12;
        for (int i = 0; i < 6 && stat_ok; i++)
            if (m_line[6+i] != KW_STAT[47-8*i -: 8])
                stat_ok = 0;
        if (stat_ok)
            return ERR_NONE;
        if (!pfx_ok || n <= 11)
            return ERR_MALFORMED;
        for (int i = 0; i < 5; i++)
            if (m_line[6+i] != KW_WAKE[39-8*i -: 8])
                return ERR_MALFORMED;
        for (int i = 11; i < n; i++)
        begin
            if (m_line[i] < "0" || m_line[i] > "9")
                return ERR_MALFORMED;
            d = int'(m_line[i] - "0");
            if (acc_id > (longint'(ID_LIMIT) - d) / 10)
                return ERR_MALFORMED;
            acc_id = acc_id * 10 + d;
        end
        if (acc_id == 0)
            return ERR_MALFORMED;
        if (acc_id == m_id)
            return ERR_NONE;
        if (model_busy())
            return ERR_BUSY;
        if (m_failed)
            return ERR_RADIO;
        m_id = acc_id[30:0];
        m_phase = PH_QUEUED;
        m_accepted++;
        return ERR_NONE;
    endfunction

    // Take in a radio snapshot and move the request phase on.
    function automatic void apply_snapshot(host_item_t it);
        if (it.flags[4] && !m_failed)
            m_local_fail++;
        {m_failed, m_init, m_ready, m_conf, m_rbusy} = it.flags;
        m_bursts = it.bursts;
        m_fails = it.fails;
        if (model_active())
        begin
            if (m_failed)
                m_phase = PH_FAILED;
            else if (m_init && !m_conf)
                m_phase = PH_UNCONF;
            else if (m_phase == PH_BCAST)
            begin
                if (m_fails != m_fail_base)
                    m_phase = PH_FAILED;
                else if (m_bursts != m_burst_base && !m_rbusy)
                    m_phase = PH_COMPLETE;
            end
        end
        else if (m_id == 0)
        begin
            if (m_failed)
                m_phase = PH_FAILED;
            else if (m_init && !m_conf)
                m_phase = PH_UNCONF;
        end
    endfunction

    // Work out the status record that one transaction produces.
    function automatic status_rec_t predict_status(host_item_t it);
        status_rec_t r;
        r.taken = 0;
        r.resp = 0;
        r.err = ERR_NONE;
        case (it.cmd)
            CMD_BYTE:
                if (m_link)
                begin
                    r.taken = 1;
                    if (it.data == CH_LF)
                    begin
                        r.resp = 1;
                        r.err = m_bad ? ERR_MALFORMED : parse_stored_line();
                        m_len = 0;
                        m_bad = 0;
                    end
                    else if (m_len >= LINE_MAX ||
                             (it.data != CH_CR && (it.data < CH_LO || it.data > CH_HI)))
                        m_bad = 1;
                    else if (!m_bad)
                    begin
                        m_line[m_len] = it.data;
                        m_len++;
                    end
                end
            CMD_LINK:
            begin
                if (!it.up)
                begin
                    m_len = 0;
                    m_bad = 0;
                end
                m_link = it.up;
            end
            CMD_STATUS:
                apply_snapshot(it);
            default:
                if (model_wanted())
                begin
                    if (it.ok)
                    begin
                        m_burst_base = m_bursts;
                        m_fail_base = m_fails;
                        m_phase = PH_BCAST;
                    end
                    else
                    begin
                        m_local_fail++;
                        m_phase = PH_FAILED;
                    end
                end
        endcase
        r.phase = m_phase;
        r.id = m_id;
        r.accepted = m_accepted;
        r.bursts = m_bursts;
        r.failures = m_fails + m_local_fail;
        r.rdy = m_ready;
        r.conf = m_conf;
        r.busy = model_busy();
        r.wanted = model_wanted();
        return r;
    endfunction

    // Stimulus helpers: every field not used by the command is random noise.
    function automatic host_item_t noise_item(cmd_t c);
        host_item_t it;
        it.cmd = c;
        it.data = 8'($urandom);
        it.up = 1'($urandom);
        it.ok = 1'($urandom);
        it.flags = 5'($urandom);
        it.bursts = $urandom;
        it.fails = $urandom;
        return it;
    endfunction

    task automatic send_byte(logic [7:0] b);
        host_item_t it;
        it = noise_item(CMD_BYTE);
        it.data = b;
        host_feed.push_back(it);
    endtask

    task automatic send_link(bit up);
        host_item_t it;
        it = noise_item(CMD_LINK);
        it.up = up;
        host_feed.push_back(it);
    endtask

    task automatic send_snapshot(logic [4:0] f, logic [31:0] b, logic [31:0] e);
        host_item_t it;
        it = noise_item(CMD_STATUS);
        it.flags = f;
        it.bursts = b;
        it.fails = e;
        host_feed.push_back(it);
    endtask

    task automatic send_dispatch(bit ok);
        host_item_t it;
        it = noise_item(CMD_DISPATCH);
        it.ok = ok;
        host_feed.push_back(it);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_prefix();
        for (int i = 0; i < 6; i++)
            send_byte(PREFIX[47-8*i -: 8]);
    endtask

    task automatic send_status_line(bit cr);
        send_prefix();
        for (int i = 0; i < 6; i++)
            send_byte(KW_STAT[47-8*i -: 8]);
        if (cr)
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_wake_line(string digits, bit cr);
        send_prefix();
        for (int i = 0; i < 5; i++)
            send_byte(KW_WAKE[39-8*i -: 8]);
        send_text(digits);
        if (cr)
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // A mostly healthy radio snapshot, with counters that advance now and then and sometimes jump.
    task automatic send_radio_view();
        logic [4:0] f;
        if ($urandom_range(0, 99) < 15)
            snap_bursts += 1;
        if ($urandom_range(0, 99) < 5)
            snap_fails += 1;
        if ($urandom_range(0, 99) < 5)
        begin
            snap_bursts = $urandom;
            snap_fails = $urandom;
        end
        f[4] = $urandom_range(0, 99) < 8;
        f[3] = $urandom_range(0, 99) < 85;
        f[2] = $urandom_range(0, 99) < 80;
        f[1] = $urandom_range(0, 99) < 85;
        f[0] = $urandom_range(0, 99) < 25;
        send_snapshot(f, snap_bursts, snap_fails);
    endtask

    task automatic random_round();
        int    r;
        int    n;
        string s;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            case ($urandom_range(0, 5))
                0, 1: s = $sformatf("%0d", $urandom_range(1, 4));
                2: s = $sformatf("%0d", $urandom_range(1, 32'h7fffffff));
                3: s = $sformatf("000%0d", $urandom_range(0, 99));
                4: s = $sformatf("%0d", 64'h7ffffff0 + $urandom_range(0, 31));
                default: s = $sformatf("%0d", $urandom);
            endcase
            send_wake_line(s, $urandom_range(0, 9) == 0);
        end
        else if (r < 42)
            send_status_line(1'($urandom_range(0, 1)));
        else if (r < 62)
            send_radio_view();
        else if (r < 77)
            send_dispatch($urandom_range(0, 99) < 80);
        else if (r < 82)
            send_link($urandom_range(0, 99) < 75);
        else if (r < 90)
        begin
            // Broken line: random bytes, sometimes past the store's end.
            n = $urandom_range(0, 9) == 0 ? $urandom_range(60, 70) : $urandom_range(0, 14);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 3) == 0 ?
                             $urandom : $urandom_range(32, 126)));
            send_byte(CH_LF);
        end
        else
            send_byte(8'($urandom));
    endtask

    // Driver: offers pending transactions and updates the model on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            cycle_no <= cycle_no + 1;
            if (in_valid && in_ready)
                expected_status.push_back(predict_status(in_flight));
            if (!in_valid || in_ready)
            begin
                if (host_feed.size() != 0 &&
                    ((cycle_no > 1000 && cycle_no < 2500) || $urandom_range(0, 99) >= 32))
                begin
                    in_flight = host_feed.pop_front();
                    command <= in_flight.cmd;
                    data_byte <= in_flight.data;
                    link_up <= in_flight.up;
                    dispatch_ok <= in_flight.ok;
                    {radio_failed, radio_initialized, radio_armed, wake_configured,
                     wake_busy} <= in_flight.flags;
                    burst_count <= in_flight.bursts;
                    radio_failure_count <= in_flight.fails;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness, with one long hold-off to back the block up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (cycle_no == 3000)
        begin
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (cycle_no > 1000 && cycle_no < 2500) || $urandom_range(0, 99) >= 32;
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        status_rec_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result transaction", $realtime);
                error_total++;
            end
            else
            begin
                e = expected_status.pop_front();
                if ({byte_taken, response_valid, error_code, request_state, current_request,
                     accepted_count, bursts_reported, failure_total, ready_flag,
                     configured_flag, busy_flag, dispatch_wanted} !==
                    {e.taken, e.resp, e.err, e.phase, e.id, e.accepted, e.bursts,
                     e.failures, e.rdy, e.conf, e.busy, e.wanted})
                begin
                    $display("%0t: mismatch expected tk=%b rv=%b err=%0d st=%0d id=%0d",
                             $realtime, e.taken, e.resp, e.err, e.phase, e.id,
                             " acc=%0d bur=%0d fail=%0d rdy=%b cf=%b bsy=%b dw=%b",
                             e.accepted, e.bursts, e.failures, e.rdy, e.conf,
                             e.busy, e.wanted);
                    $display("%0t: mismatch actual   tk=%b rv=%b err=%0d st=%0d id=%0d",
                             $realtime, byte_taken, response_valid, error_code,
                             request_state, current_request,
                             " acc=%0d bur=%0d fail=%0d rdy=%b cf=%b bsy=%b dw=%b",
                             accepted_count, bursts_reported, failure_total,
                             ready_flag, configured_flag, busy_flag, dispatch_wanted);
                    error_total++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("wake_request_line_controller verification failed");
            $finish;
        end
    end

    initial
    begin
        // Directed: link down byte, snapshot extremes, each line kind and edge.
        send_byte("S");
        send_link(1);
        send_snapshot(5'b11111, 32'hffffffff, 32'hffffffff);
        send_snapshot(5'b00000, 32'h0, 32'h0);
        send_status_line(0);
        send_dispatch(1);
        send_wake_line("0", 0);
        send_wake_line("2147483648", 0);
        send_snapshot(5'b01110, 32'd5, 32'd0);
        send_wake_line("2147483647", 1);
        send_wake_line("2147483647", 0);
        send_wake_line("12", 0);
        send_dispatch(1);
        send_snapshot(5'b01110, 32'd6, 32'd0);
        send_wake_line("0007", 0);
        send_dispatch(0);
        send_text("SP\r\r");
        send_byte(CH_LF);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(CH_LF);
        for (int i = 0; i < 66; i++)
            send_byte("9");
        send_byte(CH_LF);
        send_text("SP");
        send_link(0);
        send_link(1);
        send_snapshot(5'b10110, 32'd6, 32'd1);
        send_wake_line("9", 0);
        snap_bursts = 32'd6;
        snap_fails = 32'd1;
        while (host_feed.size() < ITEM_GOAL)
            random_round();
        wait (host_feed.size() == 0);
        @(posedge clk);
        while (in_valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_total == 0 && expected_status.size() == 0)
            $display("wake_request_line_controller verification clean");
        else
            $display("wake_request_line_controller verification failed");
        $finish;
    end

endmodule
